// ----- rtl/core/r2fft_pkg.sv -----
// Package for the radix-2 FFT unit: sizes, sequencer states and twiddle ROM.
// Self-contained; used by radix2_complex_fft_unit.
package r2fft_pkg;

  localparam int unsigned Points    = 64;
  localparam int unsigned LogPoints = 6;
  localparam int unsigned DataW     = 24;
  localparam int unsigned SampW     = 16;
  localparam int unsigned TwW       = 16;
  localparam int unsigned ProdW     = DataW + TwW;
  localparam int unsigned AccW      = ProdW + 1;

  localparam logic [1:0] RegInverse = 2'd0;

  typedef logic [LogPoints-1:0]   addr_t;
  typedef logic [LogPoints-2:0]   tw_idx_t;
  typedef logic signed [TwW-1:0]  tw_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDV,
    ST_RDU,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_RND,
    ST_WU,
    ST_WV,
    ST_OUT
  } state_e;

  // Bit-reversed address.
  function automatic addr_t bit_rev(input addr_t a);
    addr_t r;
    for (int b = 0; b < LogPoints; b++) begin
      r[LogPoints-1-b] = a[b];
    end
    return r;
  endfunction

  // Quarter wave, entries 0..Points/4, Q1.15 {cos, sin}.
  function automatic logic [2*TwW-1:0] tw_quarter(input logic [4:0] kk);
    logic [2*TwW-1:0] v;
    unique case (kk)
      5'd0:    v = {16'sd32767, 16'sd0};
      5'd1:    v = {16'sd32610, 16'sd3212};
      5'd2:    v = {16'sd32138, 16'sd6393};
      5'd3:    v = {16'sd31357, 16'sd9512};
      5'd4:    v = {16'sd30274, 16'sd12540};
      5'd5:    v = {16'sd28899, 16'sd15447};
      5'd6:    v = {16'sd27246, 16'sd18205};
      5'd7:    v = {16'sd25330, 16'sd20788};
      5'd8:    v = {16'sd23170, 16'sd23170};
      5'd9:    v = {16'sd20788, 16'sd25330};
      5'd10:   v = {16'sd18205, 16'sd27246};
      5'd11:   v = {16'sd15447, 16'sd28899};
      5'd12:   v = {16'sd12540, 16'sd30274};
      5'd13:   v = {16'sd9512,  16'sd31357};
      5'd14:   v = {16'sd6393,  16'sd32138};
      5'd15:   v = {16'sd3212,  16'sd32610};
      5'd16:   v = {16'sd0,     16'sd32767};
      default: v = '0;
    endcase
    return v;
  endfunction

  // Cosine of 2*pi*k/Points in Q1.15; second quadrant mirrors the first.
  function automatic tw_t tw_cos(input tw_idx_t k);
    logic [2*TwW-1:0] q;
    if (k > tw_idx_t'(Points/4)) begin
      q = tw_quarter(5'(6'd32 - {1'b0, k}));
      return -tw_t'(q[2*TwW-1:TwW]);
    end
    q = tw_quarter(5'(k));
    return tw_t'(q[2*TwW-1:TwW]);
  endfunction

  function automatic tw_t tw_sin(input tw_idx_t k);
    logic [2*TwW-1:0] q;
    if (k > tw_idx_t'(Points/4)) begin
      q = tw_quarter(5'(6'd32 - {1'b0, k}));
    end else begin
      q = tw_quarter(5'(k));
    end
    return tw_t'(q[TwW-1:0]);
  endfunction

  function automatic logic signed [DataW-1:0] sat24(input logic signed [DataW+2:0] v);
    if (v > (DataW+3)'(signed'(27'sd8388607)))  return 24'sh7FFFFF;
    if (v < (DataW+3)'(signed'(-27'sd8388608))) return 24'sh800000;
    return v[DataW-1:0];
  endfunction

endpackage

// ----- rtl/core/radix2_complex_fft_unit.sv -----
// Operation: a frame of 64 words is loaded one word per accepted start while idle;
// after the last word the unit runs 192 butterflies, each stepping through RDV, RDU,
// M0-M3, RND, WU and WV on one shared 24x16 multiplier, then streams 64 bins, one a cycle.
// Start is ignored while busy; busy is high from the last load until the output sweep ends.
// The receiver cannot stall: bins appear on one-cycle strobes.
// Reset: asynchronous, active low; clears sequencer, load count and inverse_direction.
module radix2_complex_fft_unit
  import r2fft_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [SampW-1:0] sample_real_i,
  input  logic signed [SampW-1:0] sample_imag_i,
  output logic                    bin_valid_o,
  output logic signed [DataW-1:0] bin_real_o,
  output logic signed [DataW-1:0] bin_imag_o,
  output logic [5:0]              bin_index_o,
  output logic                    last_bin_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [1:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // Configuration register: inverse direction; the user must write it only while idle, the block does not enforce this.
  logic inv_q;
  assign pready = 1'b1;
  assign prdata = (paddr == RegInverse) ? {31'd0, inv_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == RegInverse) begin
      inv_q <= pwdata[0];
    end
  end

  // Sequencer state.
  state_e state_q, state_d;
  addr_t  load_cnt_q, load_cnt_d;
  logic [2:0] stage_q, stage_d;            // butterfly stage, 0..LogPoints-1
  logic [LogPoints-2:0] bfly_q, bfly_d;    // butterfly within stage
  logic [LogPoints:0] out_cnt_q, out_cnt_d;
  logic tf_inv_q, tf_inv_d;

  // Working store: one write port, one registered read port.
  logic [2*DataW-1:0] mem [Points];
  logic [2*DataW-1:0] rdata_q;
  logic               mem_we;
  addr_t              mem_waddr, mem_raddr;
  logic [2*DataW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Butterfly addressing: insert a zero bit at position stage into the butterfly number.
  addr_t   low_mask, u_addr, v_addr, half_bit;
  tw_idx_t tw_k;
  always_comb begin
    half_bit = addr_t'(1) << stage_q;
    low_mask = half_bit - addr_t'(1);
    u_addr   = ((addr_t'(bfly_q) & ~low_mask) << 1) | (addr_t'(bfly_q) & low_mask);
    v_addr   = u_addr | half_bit;
    tw_k     = tw_idx_t'((addr_t'(bfly_q) & low_mask) << (3'(LogPoints - 1) - stage_q));
  end

  // Operand and accumulator registers of the shared multiplier.
  logic signed [DataW-1:0] ar_q, ai_q, br_q, bi_q;
  tw_t                     wr_q, wi_q;
  logic signed [AccW-1:0]  accr_q, acci_q;
  logic signed [DataW+1:0] vr_q, vi_q;
  logic signed [DataW-1:0] mul_a;
  tw_t                     mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  rnd_r, rnd_i;

  always_comb begin
    unique case (state_q)
      ST_M0:   begin mul_a = br_q; mul_b = wr_q; end
      ST_M1:   begin mul_a = bi_q; mul_b = wi_q; end
      ST_M2:   begin mul_a = br_q; mul_b = wi_q; end
      default: begin mul_a = bi_q; mul_b = wr_q; end
    endcase
    prod  = mul_a * mul_b;
    // Round to nearest, ties toward +inf.
    rnd_r = (accr_q + AccW'(16384)) >>> 15;
    rnd_i = (acci_q + AccW'(16384)) >>> 15;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_RDV: begin
        wr_q <= tw_cos(tw_k);
        wi_q <= tf_inv_q ? tw_sin(tw_k) : -tw_sin(tw_k);
      end
      ST_RDU: begin
        br_q <= rdata_q[2*DataW-1:DataW];
        bi_q <= rdata_q[DataW-1:0];
      end
      ST_M0: begin
        ar_q   <= rdata_q[2*DataW-1:DataW];
        ai_q   <= rdata_q[DataW-1:0];
        accr_q <= AccW'(prod);
      end
      ST_M1: accr_q <= accr_q - AccW'(prod);
      ST_M2: acci_q <= AccW'(prod);
      ST_M3: acci_q <= acci_q + AccW'(prod);
      ST_RND: begin
        vr_q <= rnd_r[DataW+1:0];
        vi_q <= rnd_i[DataW+1:0];
      end
      default: ;
    endcase
  end

  // Next state, store port control.
  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    stage_d    = stage_q;
    bfly_d     = bfly_q;
    out_cnt_d  = out_cnt_q;
    tf_inv_d   = tf_inv_q;
    mem_we     = 1'b0;
    mem_waddr  = u_addr;
    mem_wdata  = '0;
    mem_raddr  = v_addr;
    unique case (state_q)
      ST_IDLE: begin
        // Load in bit-reversed order so the permutation costs nothing.
        mem_waddr = bit_rev(load_cnt_q);
        mem_wdata = {DataW'(sample_real_i), DataW'(sample_imag_i)};
        if (start) begin
          mem_we     = 1'b1;
          load_cnt_d = load_cnt_q + addr_t'(1);
          if (load_cnt_q == addr_t'(Points - 1)) begin
            state_d  = ST_RDV;
            stage_d  = '0;
            bfly_d   = '0;
            tf_inv_d = inv_q;
          end
        end
      end
      ST_RDV: state_d = ST_RDU;
      ST_RDU: begin
        mem_raddr = u_addr;
        state_d   = ST_M0;
      end
      ST_M0:  state_d = ST_M1;
      ST_M1:  state_d = ST_M2;
      ST_M2:  state_d = ST_M3;
      ST_M3:  state_d = ST_RND;
      ST_RND: state_d = ST_WU;
      ST_WU: begin
        mem_we    = 1'b1;
        mem_waddr = u_addr;
        mem_wdata = {sat24((DataW+3)'(ar_q) + (DataW+3)'(vr_q)),
                     sat24((DataW+3)'(ai_q) + (DataW+3)'(vi_q))};
        state_d   = ST_WV;
      end
      ST_WV: begin
        mem_we    = 1'b1;
        mem_waddr = v_addr;
        mem_wdata = {sat24((DataW+3)'(ar_q) - (DataW+3)'(vr_q)),
                     sat24((DataW+3)'(ai_q) - (DataW+3)'(vi_q))};
        bfly_d    = bfly_q + 1'b1;
        state_d   = ST_RDV;
        if (bfly_q == '1) begin
          stage_d = stage_q + 3'd1;
          if (stage_q == 3'(LogPoints - 1)) begin
            state_d   = ST_OUT;
            out_cnt_d = '0;
          end
        end
      end
      ST_OUT: begin
        // Sweep the store in natural order; data lands in rdata_q in the cycle after the read.
        mem_raddr = out_cnt_q[LogPoints-1:0];
        out_cnt_d = out_cnt_q + 1'b1;
        if (out_cnt_q == (LogPoints+1)'(Points - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output strobe is registered, so it follows the read into the next cycle, with the data.
  logic  pend_q;
  addr_t idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      load_cnt_q <= '0;
      stage_q    <= '0;
      bfly_q     <= '0;
      out_cnt_q  <= '0;
      tf_inv_q   <= 1'b0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      stage_q    <= stage_d;
      bfly_q     <= bfly_d;
      out_cnt_q  <= out_cnt_d;
      tf_inv_q   <= tf_inv_d;
      pend_q     <= (state_q == ST_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= out_cnt_q[LogPoints-1:0];
  end

  assign busy        = (state_q != ST_IDLE);
  assign bin_valid_o = pend_q;
  assign bin_real_o  = rdata_q[2*DataW-1:DataW];
  assign bin_imag_o  = rdata_q[DataW-1:0];
  assign bin_index_o = 6'(idx_q);
  assign last_bin_o  = pend_q && (idx_q == addr_t'(Points - 1));

  // Checks on the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_bin_o |-> bin_index_o == 6'(Points - 1))
    else $error("last bin flagged on wrong index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_valid_o && !last_bin_o |=> bin_valid_o)
    else $error("bin sweep broken before last bin");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |-> !mem_we)
    else $error("store written during output sweep");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WV && bfly_q == '1 && stage_q == 3'(LogPoints - 1) |=> state_q == ST_OUT)
    else $error("transform did not hand over to output sweep");

endmodule
